// ===== rtl/core/jtag_tap_shift_sequencer_macros.svh =====
// Assertion macros for the JTAG shift sequencer.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef JTAG_TAP_SHIFT_SEQUENCER_MACROS_SVH
`define JTAG_TAP_SHIFT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define JTSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JTSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jtss_pkg.sv =====
// Shared types and codes for the JTAG shift sequencer.
// No dependencies.
package jtss_pkg;

  localparam int WORD_W  = 16;
  localparam int PHASE_W = 6;
  localparam int AI_W    = 10;

  typedef logic [2:0]        act_t;
  typedef logic [2:0]        tap_st_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [AI_W-1:0]   ainstr_t;

  localparam act_t ACT_TICK   = 3'd0;
  localparam act_t ACT_RESET  = 3'd1;
  localparam act_t ACT_GOIDLE = 3'd2;
  localparam act_t ACT_LEAVE  = 3'd3;
  localparam act_t ACT_INSTR  = 3'd4;
  localparam act_t ACT_DATA   = 3'd5;
  localparam act_t ACT_ADDR   = 3'd6;
  localparam act_t ACT_UNUSED = 3'd7;
  localparam act_t OP_NONE    = 3'd0;

  localparam tap_st_t ST_RESET    = 3'd0;
  localparam tap_st_t ST_IDLE     = 3'd1;
  localparam tap_st_t ST_IR_SHIFT = 3'd2;
  localparam tap_st_t ST_IR_EXIT1 = 3'd3;
  localparam tap_st_t ST_DR_SHIFT = 3'd4;
  localparam tap_st_t ST_DR_EXIT1 = 3'd5;

  typedef struct packed {
    logic    tms;
    logic    tdi;
    tap_st_t tap_state;
    logic    done_res;
    word_t   captured_data;
  } res_t;

  typedef struct packed {
    logic    tms;
    logic    tdi;
    tap_st_t st;
    logic    fin;
  } pulse_t;

  typedef struct packed {
    logic    busy;
    tap_st_t tap_state;
  } stat_t;

endpackage

// ===== rtl/core/jtss_in_if.sv =====
// Command/tick request channel of the JTAG shift sequencer.
// Depends on jtss_pkg.
interface jtss_in_if;
  logic              valid;
  logic              ready;
  jtss_pkg::act_t    action;
  jtss_pkg::word_t   value;
  logic              last_word;
  logic              tdo;

  modport source (output valid, action, value, last_word, tdo, input ready);
  modport sink   (input valid, action, value, last_word, tdo, output ready);
endinterface

// ===== rtl/core/jtss_out_if.sv =====
// Pulse result channel of the JTAG shift sequencer.
// Depends on jtss_pkg.
interface jtss_out_if;
  logic              valid;
  logic              ready;
  logic              tms;
  logic              tdi;
  jtss_pkg::tap_st_t tap_state;
  logic              done_res;
  jtss_pkg::word_t   captured_data;

  modport source (output valid, tms, tdi, tap_state, done_res, captured_data, input ready);
  modport sink   (input valid, tms, tdi, tap_state, done_res, captured_data, output ready);
endinterface

// ===== rtl/core/jtss_cfg_if.sv =====
// Configuration write channel (address instruction register).
// Depends on jtss_pkg.
interface jtss_cfg_if;
  logic                valid;
  logic                ready;
  jtss_pkg::ainstr_t   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/jtss_core.sv =====
// Sequencer state and per-request pulse logic.
// Depends on jtss_pkg.
module jtss_core #(
  parameter int IR_BITS      = 10,
  parameter int DATA_BITS    = 16,
  parameter int ADDRESS_BITS = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  jtss_pkg::act_t    action,
  input  jtss_pkg::word_t   value,
  input  logic              last_word,
  input  logic              tdo,
  input  jtss_pkg::ainstr_t addr_instr,
  output logic              res_valid,
  output jtss_pkg::res_t    res,
  output jtss_pkg::stat_t   stat
);

  localparam jtss_pkg::word_t IR_MASK   = jtss_pkg::WORD_W'((32'd1 << IR_BITS) - 1);
  localparam jtss_pkg::word_t DATA_MASK = jtss_pkg::WORD_W'((32'd1 << DATA_BITS) - 1);
  localparam jtss_pkg::word_t ADDR_MASK = jtss_pkg::WORD_W'((32'd1 << ADDRESS_BITS) - 1);
  localparam jtss_pkg::phase_t IR_SH_END = jtss_pkg::PHASE_W'(6 + IR_BITS);
  localparam jtss_pkg::phase_t IR_LASTI  = jtss_pkg::PHASE_W'(IR_BITS - 1);
  localparam jtss_pkg::phase_t IR_END    = jtss_pkg::PHASE_W'(8 + IR_BITS);
  localparam jtss_pkg::phase_t DR_SH_END = jtss_pkg::PHASE_W'(3 + DATA_BITS);
  localparam jtss_pkg::phase_t DR_LASTI  = jtss_pkg::PHASE_W'(DATA_BITS - 1);
  localparam jtss_pkg::phase_t AD_SH_END = jtss_pkg::PHASE_W'(3 + ADDRESS_BITS);
  localparam jtss_pkg::phase_t AD_LASTI  = jtss_pkg::PHASE_W'(ADDRESS_BITS - 1);

  jtss_pkg::tap_st_t state_r;
  logic              tms_r;
  logic              tdi_r;
  jtss_pkg::act_t    op_r;
  jtss_pkg::phase_t  phase_r;
  jtss_pkg::word_t   shift_r;
  jtss_pkg::word_t   capt_r;
  logic              end_r;

  function automatic jtss_pkg::pulse_t ir_step(jtss_pkg::phase_t p, jtss_pkg::word_t code,
                                               jtss_pkg::pulse_t cur);
    jtss_pkg::pulse_t r;
    jtss_pkg::phase_t idx;
    r   = cur;
    idx = p - 6'd6;
    if (p == 6'd0) begin
      r.tms = 1'b1;
    end else if (p == 6'd1) begin
      r.tms = 1'b0;
      r.st  = jtss_pkg::ST_IDLE;
    end else if (p == 6'd2 || p == 6'd3) begin
      r.tms = 1'b1;
    end else if (p == 6'd4) begin
      r.tms = 1'b0;
    end else if (p == 6'd5) begin
      r.tms = 1'b0;
      r.st  = jtss_pkg::ST_IR_SHIFT;
    end else if (p < IR_SH_END) begin
      r.tdi = code[idx[3:0]];
      if (idx == IR_LASTI) begin
        r.tms = 1'b1;
        r.st  = jtss_pkg::ST_IR_EXIT1;
      end
    end else if (p == IR_SH_END) begin
      r.tms = 1'b1;
    end else begin
      r.tms = 1'b0;
      r.st  = jtss_pkg::ST_IDLE;
      r.fin = 1'b1;
    end
    return r;
  endfunction

  logic              busy;
  logic              tick;
  logic              cmd;
  logic              in_exit1;
  jtss_pkg::pulse_t  cur;
  jtss_pkg::pulse_t  pl;
  jtss_pkg::pulse_t  irp;
  jtss_pkg::phase_t  q;
  jtss_pkg::phase_t  di;
  jtss_pkg::word_t   capt_nxt;
  jtss_pkg::word_t   captured;

  assign busy     = (op_r != jtss_pkg::OP_NONE);
  assign tick     = accept && (action == jtss_pkg::ACT_TICK) && busy;
  assign cmd      = accept && (action != jtss_pkg::ACT_TICK) &&
                    (action != jtss_pkg::ACT_UNUSED) && !busy;
  assign in_exit1 = (state_r == jtss_pkg::ST_IR_EXIT1) || (state_r == jtss_pkg::ST_DR_EXIT1);
  assign cur      = '{tms: tms_r, tdi: tdi_r, st: state_r, fin: 1'b0};
  assign q        = phase_r - IR_END;
  assign di       = phase_r - 6'd3;

  always_comb begin
    pl       = cur;
    capt_nxt = capt_r;
    captured = '0;
    irp      = ir_step(phase_r,
                       (op_r == jtss_pkg::ACT_ADDR) ?
                         (jtss_pkg::WORD_W'(addr_instr) & IR_MASK) : (shift_r & IR_MASK),
                       cur);
    case (op_r)
      jtss_pkg::ACT_RESET: begin
        pl.tms = 1'b1;
        if (phase_r >= 6'd4) begin
          pl.st  = jtss_pkg::ST_RESET;
          pl.fin = 1'b1;
        end
      end
      jtss_pkg::ACT_GOIDLE: begin
        pl.tms = 1'b0;
        pl.st  = jtss_pkg::ST_IDLE;
        pl.fin = 1'b1;
      end
      jtss_pkg::ACT_LEAVE: begin
        if (phase_r == 6'd0) begin
          pl.tms = 1'b1;
        end else begin
          pl.tms = 1'b0;
          pl.st  = jtss_pkg::ST_IDLE;
          pl.fin = 1'b1;
        end
      end
      jtss_pkg::ACT_INSTR: begin
        pl = irp;
      end
      jtss_pkg::ACT_DATA: begin
        if (phase_r == 6'd0) begin
          pl.tms = 1'b1;
        end else if (phase_r == 6'd1) begin
          pl.tms = 1'b0;
        end else if (phase_r == 6'd2) begin
          pl.tms = 1'b0;
          pl.st  = jtss_pkg::ST_DR_SHIFT;
        end else if (phase_r < DR_SH_END) begin
          pl.tdi = shift_r[di[3:0]];
          if (tdo) begin
            capt_nxt[di[3:0]] = 1'b1;
          end
          if (di == DR_LASTI) begin
            if (end_r) begin
              pl.tms = 1'b1;
              pl.st  = jtss_pkg::ST_DR_EXIT1;
            end else begin
              pl.fin = 1'b1;
            end
          end
        end else if (phase_r == DR_SH_END) begin
          pl.tms = 1'b1;
        end else begin
          pl.tms = 1'b0;
          pl.st  = jtss_pkg::ST_IDLE;
          pl.fin = 1'b1;
        end
        if (pl.fin) begin
          captured = capt_nxt;
        end
      end
      jtss_pkg::ACT_ADDR: begin
        if (phase_r < IR_END) begin
          pl     = irp;
          pl.fin = 1'b0;
        end else if (q == 6'd0) begin
          pl.tms = 1'b1;
        end else if (q == 6'd1) begin
          pl.tms = 1'b0;
        end else if (q == 6'd2) begin
          pl.tms = 1'b0;
          pl.st  = jtss_pkg::ST_DR_SHIFT;
        end else if (q < AD_SH_END) begin
          pl.tdi = shift_r[4'(q - 6'd3)];
          if ((q - 6'd3) == AD_LASTI) begin
            pl.tms = 1'b1;
            pl.st  = jtss_pkg::ST_DR_EXIT1;
          end
        end else if (q == AD_SH_END) begin
          pl.tms = 1'b1;
        end else begin
          pl.tms = 1'b0;
          pl.st  = jtss_pkg::ST_IDLE;
          pl.fin = 1'b1;
        end
      end
      default: begin
        pl = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jtss_pkg::ST_RESET;
      tms_r   <= 1'b1;
      tdi_r   <= 1'b0;
      op_r    <= jtss_pkg::OP_NONE;
      phase_r <= '0;
      shift_r <= '0;
      capt_r  <= '0;
      end_r   <= 1'b0;
    end else if (tick) begin
      state_r <= pl.st;
      tms_r   <= pl.tms;
      tdi_r   <= pl.tdi;
      capt_r  <= capt_nxt;
      if (pl.fin) begin
        op_r    <= jtss_pkg::OP_NONE;
        phase_r <= '0;
      end else begin
        phase_r <= phase_r + 6'd1;
      end
    end else if (cmd) begin
      op_r <= action;
      case (action)
        jtss_pkg::ACT_LEAVE, jtss_pkg::ACT_INSTR: begin
          phase_r <= in_exit1 ? 6'd0 : 6'd1;
          shift_r <= value & IR_MASK;
        end
        jtss_pkg::ACT_ADDR: begin
          phase_r <= in_exit1 ? 6'd0 : 6'd1;
          shift_r <= value & ADDR_MASK;
        end
        jtss_pkg::ACT_DATA: begin
          phase_r <= (state_r == jtss_pkg::ST_IDLE) ? 6'd0 : 6'd3;
          shift_r <= value & DATA_MASK;
          capt_r  <= '0;
          end_r   <= last_word;
        end
        default: begin
          phase_r <= '0;
        end
      endcase
    end
  end

  assign res_valid         = tick;
  assign res.tms           = pl.tms;
  assign res.tdi           = pl.tdi;
  assign res.tap_state     = pl.st;
  assign res.done_res      = pl.fin;
  assign res.captured_data = captured;
  assign stat.busy         = busy;
  assign stat.tap_state    = state_r;

endmodule

// ===== rtl/core/jtss_out_buf.sv =====
// Two-entry registered result buffer (output register plus skid slot).
// Depends on jtss_pkg.
module jtss_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jtss_pkg::res_t push_data,
  output logic           has_room,
  output logic           out_valid,
  input  logic           out_ready,
  output jtss_pkg::res_t out_data
);

  logic           v0_r;
  logic           v1_r;
  jtss_pkg::res_t d0_r;
  jtss_pkg::res_t d1_r;
  logic           head_free;

  assign head_free = !v0_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (head_free) begin
      if (v1_r) begin
        v0_r <= 1'b1;
        v1_r <= push;
      end else begin
        v0_r <= push;
      end
    end else if (push) begin
      v1_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_free) begin
      if (v1_r) begin
        d0_r <= d1_r;
        if (push) begin
          d1_r <= push_data;
        end
      end else if (push) begin
        d0_r <= push_data;
      end
    end else if (push) begin
      d1_r <= push_data;
    end
  end

  assign has_room  = !v1_r;
  assign out_valid = v0_r;
  assign out_data  = d0_r;

endmodule

// ===== rtl/core/jtag_tap_shift_sequencer.sv =====
// JTAG master sequencer top level: config register, sequencer core, result buffer.
// Depends on jtss_pkg, jtss_in_if, jtss_out_if, jtss_cfg_if, jtss_core, jtss_out_buf.
//
// Usage: in_chan takes requests. A command (action 1..6) starts one operation
// (TAP reset, go idle, leave to idle, instruction, data word, address) and
// gives no result. Each following tick request (action 0) makes one TCK pulse,
// reported on out_chan with its TMS/TDI levels, tracked TAP state, a done flag
// and, at the end of a data shift, the captured TDO word. Commands while an
// operation runs and ticks while none runs are dropped.
// cfg_chan writes the address instruction code; it is always ready.
// Each tick's result is registered in the result buffer before it reaches out_chan.
// Throughput: one request per cycle while in_chan is ready; the state update is a single pass.
// Stall: a two-entry result buffer keeps in_chan ready while one result waits;
// in_chan drops ready only when both entries hold untaken results.
// Reset (synchronous, rst_n low): TAP state reset, TMS high, TDI low, no
// operation running, buffer empty, address instruction zero.
`include "jtag_tap_shift_sequencer_macros.svh"

module jtag_tap_shift_sequencer #(
  parameter int IR_BITS      = 10,
  parameter int DATA_BITS    = 16,
  parameter int ADDRESS_BITS = 13
) (
  input  logic       clk,
  input  logic       rst_n,
  jtss_in_if.sink    in_chan,
  jtss_out_if.source out_chan,
  jtss_cfg_if.sink   cfg_chan
);

  jtss_pkg::ainstr_t addr_instr_r;
  logic              accept;
  logic              res_valid;
  jtss_pkg::res_t    res;
  jtss_pkg::res_t    out_data;
  jtss_pkg::stat_t   stat;
  logic              has_room;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_instr_r <= '0;
    end else if (cfg_chan.valid) begin
      addr_instr_r <= cfg_chan.data;
    end
  end

  assign in_chan.ready = has_room;
  assign accept        = in_chan.valid && has_room;

  jtss_core #(
    .IR_BITS      (IR_BITS),
    .DATA_BITS    (DATA_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .action     (in_chan.action),
    .value      (in_chan.value),
    .last_word  (in_chan.last_word),
    .tdo        (in_chan.tdo),
    .addr_instr (addr_instr_r),
    .res_valid  (res_valid),
    .res        (res),
    .stat       (stat)
  );

  jtss_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.tms           = out_data.tms;
  assign out_chan.tdi           = out_data.tdi;
  assign out_chan.tap_state     = out_data.tap_state;
  assign out_chan.done_res      = out_data.done_res;
  assign out_chan.captured_data = out_data.captured_data;

  `JTSS_ASSERT_NOW(a_tick_pulses, accept && in_chan.action == jtss_pkg::ACT_TICK && stat.busy, res_valid, "accepted tick while busy gave no pulse")
  `JTSS_ASSERT_NEXT(a_done_idle, res_valid && res.done_res, !stat.busy, "operation still running after done pulse")
  `JTSS_ASSERT_NEXT(a_cmd_starts, accept && !stat.busy && in_chan.action != jtss_pkg::ACT_TICK && in_chan.action != jtss_pkg::ACT_UNUSED, stat.busy, "command not started")
  `JTSS_ASSERT_NOW(a_nodata_capt, res_valid && !res.done_res, res.captured_data == '0, "captured word on a non-final pulse")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for jtag_tap_shift_sequencer: directed and random command/tick requests,
// a prediction of every TCK pulse checked in order, and random stalls on both channels.
// Depends on jtss_pkg, jtss_in_if, jtss_out_if, jtss_cfg_if and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int IR_BITS        = 10;
  localparam int DATA_BITS      = 16;
  localparam int ADDRESS_BITS   = 13;
  localparam int IDLE_PCT       = 13;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 250;

  class tap_pulse_scoreboard;
    jtss_pkg::ainstr_t ainstr_code;
    jtss_pkg::tap_st_t tap_st;
    logic              held_tms;
    logic              held_tdi;
    jtss_pkg::act_t    run_op;
    jtss_pkg::phase_t  step;
    jtss_pkg::word_t   out_word;
    jtss_pkg::word_t   in_word;
    logic              leave_after;
    jtss_pkg::res_t    expected_pulses[$];
    int                errors;

    function new();
      ainstr_code = '0;
      tap_st      = jtss_pkg::ST_RESET;
      held_tms    = 1'b1;
      held_tdi    = 1'b0;
      run_op      = jtss_pkg::OP_NONE;
      step        = '0;
      out_word    = '0;
      in_word     = '0;
      leave_after = 1'b0;
      errors      = 0;
    endfunction

    function bit busy();
      return run_op != jtss_pkg::OP_NONE;
    endfunction

    function bit ir_step(int p, jtss_pkg::ainstr_t code, inout logic tms, inout logic tdi);
      ir_step = 1'b0;
      if (p == 0) begin
        tms = 1'b1;
      end else if (p == 1) begin
        tms = 1'b0;
        tap_st = jtss_pkg::ST_IDLE;
      end else if (p == 2 || p == 3) begin
        tms = 1'b1;
      end else if (p == 4) begin
        tms = 1'b0;
      end else if (p == 5) begin
        tms = 1'b0;
        tap_st = jtss_pkg::ST_IR_SHIFT;
      end else if (p < 6 + IR_BITS) begin
        tdi = code[p-6];
        if (p - 6 == IR_BITS - 1) begin
          tms = 1'b1;
          tap_st = jtss_pkg::ST_IR_EXIT1;
        end
      end else if (p == 6 + IR_BITS) begin
        tms = 1'b1;
      end else begin
        tms = 1'b0;
        tap_st = jtss_pkg::ST_IDLE;
        ir_step = 1'b1;
      end
    endfunction

    function jtss_pkg::res_t predict_pulse(logic tdo);
      logic tms;
      logic tdi;
      logic fin;
      jtss_pkg::word_t cap;
      int p;
      int i;
      int q;
      jtss_pkg::res_t r;
      tms = held_tms;
      tdi = held_tdi;
      fin = 1'b0;
      cap = '0;
      p = int'(step);
      case (run_op)
        jtss_pkg::ACT_RESET: begin
          tms = 1'b1;
          if (p >= 4) begin
            tap_st = jtss_pkg::ST_RESET;
            fin = 1'b1;
          end
        end
        jtss_pkg::ACT_GOIDLE: begin
          tms = 1'b0;
          tap_st = jtss_pkg::ST_IDLE;
          fin = 1'b1;
        end
        jtss_pkg::ACT_LEAVE: begin
          if (p == 0) begin
            tms = 1'b1;
          end else begin
            tms = 1'b0;
            tap_st = jtss_pkg::ST_IDLE;
            fin = 1'b1;
          end
        end
        jtss_pkg::ACT_INSTR: begin
          fin = ir_step(p, out_word[IR_BITS-1:0], tms, tdi);
        end
        jtss_pkg::ACT_DATA: begin
          if (p == 0) begin
            tms = 1'b1;
          end else if (p == 1) begin
            tms = 1'b0;
          end else if (p == 2) begin
            tms = 1'b0;
            tap_st = jtss_pkg::ST_DR_SHIFT;
          end else if (p < 3 + DATA_BITS) begin
            i = p - 3;
            tdi = out_word[i];
            if (tdo) in_word[i] = 1'b1;
            if (i == DATA_BITS - 1) begin
              if (leave_after) begin
                tms = 1'b1;
                tap_st = jtss_pkg::ST_DR_EXIT1;
              end else begin
                fin = 1'b1;
              end
            end
          end else if (p == 3 + DATA_BITS) begin
            tms = 1'b1;
          end else begin
            tms = 1'b0;
            tap_st = jtss_pkg::ST_IDLE;
            fin = 1'b1;
          end
          if (fin) cap = in_word;
        end
        jtss_pkg::ACT_ADDR: begin
          if (p < 8 + IR_BITS) begin
            void'(ir_step(p, ainstr_code, tms, tdi));
          end else begin
            q = p - (8 + IR_BITS);
            if (q == 0) begin
              tms = 1'b1;
            end else if (q == 1) begin
              tms = 1'b0;
            end else if (q == 2) begin
              tms = 1'b0;
              tap_st = jtss_pkg::ST_DR_SHIFT;
            end else if (q < 3 + ADDRESS_BITS) begin
              i = q - 3;
              tdi = out_word[i];
              if (i == ADDRESS_BITS - 1) begin
                tms = 1'b1;
                tap_st = jtss_pkg::ST_DR_EXIT1;
              end
            end else if (q == 3 + ADDRESS_BITS) begin
              tms = 1'b1;
            end else begin
              tms = 1'b0;
              tap_st = jtss_pkg::ST_IDLE;
              fin = 1'b1;
            end
          end
        end
        default: ;
      endcase
      held_tms = tms;
      held_tdi = tdi;
      if (fin) begin
        run_op = jtss_pkg::OP_NONE;
        step = '0;
      end else begin
        step = step + 1'b1;
      end
      r.tms = tms;
      r.tdi = tdi;
      r.tap_state = tap_st;
      r.done_res = fin;
      r.captured_data = cap;
      return r;
    endfunction

    // returns 1 when the request starts an operation or makes a pulse
    function bit note_request(jtss_pkg::act_t a, jtss_pkg::word_t v, logic last, logic tdo);
      bit in_exit1;
      in_exit1 = (tap_st == jtss_pkg::ST_IR_EXIT1) || (tap_st == jtss_pkg::ST_DR_EXIT1);
      if (a == jtss_pkg::ACT_TICK) begin
        if (run_op == jtss_pkg::OP_NONE) return 1'b0;
        expected_pulses.push_back(predict_pulse(tdo));
        return 1'b1;
      end
      if (run_op != jtss_pkg::OP_NONE || a == jtss_pkg::ACT_UNUSED) return 1'b0;
      run_op = a;
      step = '0;
      case (a)
        jtss_pkg::ACT_LEAVE, jtss_pkg::ACT_INSTR: begin
          step = in_exit1 ? jtss_pkg::phase_t'(0) : jtss_pkg::phase_t'(1);
          out_word = v & jtss_pkg::word_t'((32'd1 << IR_BITS) - 1);
        end
        jtss_pkg::ACT_ADDR: begin
          step = in_exit1 ? jtss_pkg::phase_t'(0) : jtss_pkg::phase_t'(1);
          out_word = v & jtss_pkg::word_t'((32'd1 << ADDRESS_BITS) - 1);
        end
        jtss_pkg::ACT_DATA: begin
          step = (tap_st == jtss_pkg::ST_IDLE) ? jtss_pkg::phase_t'(0) :
                                                 jtss_pkg::phase_t'(3);
          out_word = v & jtss_pkg::word_t'((32'd1 << DATA_BITS) - 1);
          in_word = '0;
          leave_after = last;
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void cmp_field(string what, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_pulse(jtss_pkg::res_t got);
      jtss_pkg::res_t want;
      if (expected_pulses.size() == 0) begin
        $display("%0t: unexpected pulse, expected none, actual tms %0b tdi %0b state %0d",
                 $time, got.tms, got.tdi, got.tap_state);
        errors++;
        return;
      end
      want = expected_pulses.pop_front();
      cmp_field("tms", 16'(want.tms), 16'(got.tms));
      cmp_field("tdi", 16'(want.tdi), 16'(got.tdi));
      cmp_field("tap_state", 16'(want.tap_state), 16'(got.tap_state));
      cmp_field("done_res", 16'(want.done_res), 16'(got.done_res));
      cmp_field("captured_data", want.captured_data, got.captured_data);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  jtss_in_if  in_chan();
  jtss_out_if out_chan();
  jtss_cfg_if cfg_chan();

  tap_pulse_scoreboard sb;
  int n_items;
  bit calm;

  jtag_tap_shift_sequencer #(
    .IR_BITS     (IR_BITS),
    .DATA_BITS   (DATA_BITS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_req(jtss_pkg::act_t a, jtss_pkg::word_t v, logic last, logic tdo_lvl);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.action    <= a;
    in_chan.value     <= v;
    in_chan.last_word <= last;
    in_chan.tdo       <= tdo_lvl;
    do @(posedge clk); while (!in_chan.ready);
    if (sb.note_request(a, v, last, tdo_lvl)) n_items++;
  endtask

  task automatic tick(int ones_pct);
    send_req(jtss_pkg::ACT_TICK, jtss_pkg::word_t'($urandom), 1'($urandom),
             $urandom_range(0, 99) < ones_pct);
  endtask

  task automatic finish_op(int ones_pct);
    while (sb.busy()) tick(ones_pct);
  endtask

  task automatic run_op(jtss_pkg::act_t a, jtss_pkg::word_t v, logic last, int ones_pct);
    send_req(a, v, last, 1'($urandom));
    finish_op(ones_pct);
  endtask

  // only called with no operation running
  task automatic write_ainstr(jtss_pkg::ainstr_t code);
    in_chan.valid <= 1'b0;
    while (sb.expected_pulses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= code;
    do @(posedge clk); while (!cfg_chan.ready);
    sb.ainstr_code = code;
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic random_ops(int n_target);
    int stop;
    int r;
    int n_ticks;
    stop = n_items + n_target;
    while (n_items < stop) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_req(jtss_pkg::act_t'($urandom_range(1, 6)), jtss_pkg::word_t'($urandom),
                 1'($urandom), 1'($urandom));
        while (sb.busy()) begin
          if ($urandom_range(0, 99) < 5)
            send_req(jtss_pkg::act_t'($urandom_range(1, 7)), jtss_pkg::word_t'($urandom),
                     1'($urandom), 1'($urandom));
          else
            tick(50);
        end
      end else if (r < 85) begin
        tick(50);
      end else if (r < 92) begin
        send_req(jtss_pkg::ACT_UNUSED, jtss_pkg::word_t'($urandom), 1'($urandom),
                 1'($urandom));
      end else begin
        // operation cut short; later ticks carry it on
        send_req(jtss_pkg::act_t'($urandom_range(1, 6)), jtss_pkg::word_t'($urandom),
                 1'($urandom), 1'($urandom));
        n_ticks = $urandom_range(0, 5);
        repeat (n_ticks) tick(50);
      end
    end
    finish_op(50);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int n_res;
    int hold_left;
    bit held;
    jtss_pkg::res_t got;
    n_res = 0;
    hold_left = 0;
    held = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.tms = out_chan.tms;
        got.tdi = out_chan.tdi;
        got.tap_state = out_chan.tap_state;
        got.done_res = out_chan.done_res;
        got.captured_data = out_chan.captured_data;
        sb.check_pulse(got);
        n_res++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held && n_res >= HOLD_AT_RESULT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      out_chan.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sb = new();
    n_items = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.action = jtss_pkg::ACT_TICK;
    in_chan.value = '0;
    in_chan.last_word = 1'b0;
    in_chan.tdo = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_ainstr(jtss_pkg::ainstr_t'(10'h3FF));
    // ignored while idle
    send_req(jtss_pkg::ACT_TICK, 16'hFFFF, 1'b1, 1'b1);
    send_req(jtss_pkg::ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1);
    run_op(jtss_pkg::ACT_RESET, 16'h0000, 1'b0, 50);
    // data from the reset state skips the Shift-DR entry
    run_op(jtss_pkg::ACT_DATA, 16'hFFFF, 1'b0, 100);
    run_op(jtss_pkg::ACT_GOIDLE, 16'h0000, 1'b0, 50);
    run_op(jtss_pkg::ACT_DATA, 16'h0000, 1'b1, 0);
    run_op(jtss_pkg::ACT_DATA, 16'hA5A5, 1'b0, 50);
    run_op(jtss_pkg::ACT_DATA, 16'h5A5A, 1'b1, 50);
    run_op(jtss_pkg::ACT_LEAVE, 16'hFFFF, 1'b1, 50);
    run_op(jtss_pkg::ACT_INSTR, 16'hFFFF, 1'b0, 50);
    run_op(jtss_pkg::ACT_INSTR, 16'h0000, 1'b1, 50);
    run_op(jtss_pkg::ACT_INSTR, 16'hFC00, 1'b0, 50);
    run_op(jtss_pkg::ACT_ADDR, 16'hFFFF, 1'b0, 50);
    run_op(jtss_pkg::ACT_ADDR, 16'h0000, 1'b1, 50);
    // commands while busy are dropped
    send_req(jtss_pkg::ACT_INSTR, 16'h0155, 1'b0, 1'b0);
    repeat (3) tick(50);
    send_req(jtss_pkg::ACT_DATA, 16'hFFFF, 1'b1, 1'b1);
    send_req(jtss_pkg::ACT_UNUSED, 16'h0000, 1'b0, 1'b0);
    send_req(jtss_pkg::ACT_RESET, 16'h0000, 1'b0, 1'b0);
    finish_op(50);
    // TDI held across pulses that shift nothing
    run_op(jtss_pkg::ACT_GOIDLE, 16'h0000, 1'b0, 50);
    run_op(jtss_pkg::ACT_LEAVE, 16'h0000, 1'b0, 50);

    write_ainstr(jtss_pkg::ainstr_t'(10'h000));
    run_op(jtss_pkg::ACT_ADDR, 16'h1555, 1'b0, 50);

    write_ainstr(jtss_pkg::ainstr_t'($urandom));
    random_ops(130);
    write_ainstr(jtss_pkg::ainstr_t'(10'h3FF));
    calm = 1'b1;
    random_ops(130);
    calm = 1'b0;
    write_ainstr(jtss_pkg::ainstr_t'($urandom));
    random_ops(130);
    write_ainstr(jtss_pkg::ainstr_t'(10'h000));
    random_ops(130);

    in_chan.valid <= 1'b0;
    while (sb.expected_pulses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pulses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
